@@ rtl/core/ssi_pkg.sv @@
package ssi_pkg;

    localparam int VALUE_W   = 32;
    localparam int DEPTH_DEF = 16;

    // request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_RUN    = 2'd2
    } req_t;

    // outcome of one signed compare of an A element against a B element
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

@@ rtl/core/ssi_ram.sv @@
module ssi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ssi_cmp.sv @@
module ssi_cmp (
    input  logic signed [ssi_pkg::VALUE_W-1:0] a,
    input  logic signed [ssi_pkg::VALUE_W-1:0] b,
    output ssi_pkg::cmp_res_t                  res
);

    import ssi_pkg::*;

    // single signed comparator shared by every step of the walk
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

@@ rtl/core/sorted_set_intersection.sv @@
// Sorted set intersection by a two-pointer walk.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. req_type selects the work: load A appends value to set A (ascending
// order expected), load B appends value to set B (descending order expected),
// run walks both sets. Unused codes and loads into a full set are dropped.
// Loads never raise busy, so one load per cycle is taken while no run is busy.
//
// Result channel: strobe marks each result for exactly one cycle; the receiver
// cannot stall it. A run gives the common values in ascending order, the last
// one with is_last set. An empty intersection gives one result with
// none_found and is_last set and value_res zero. A run clears both counts.
//
// Walk: a run makes S pointer steps, where S <= count_a + count_b; each
// step is one registered RAM read followed by one pass through the shared
// comparator. busy falls in the cycle that shows the last result.
//
// Reset clears the counts and the sequencer; the set stores keep no reset
// value and are read only below the counts.
module sorted_set_intersection #(
    parameter int DEPTH = ssi_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic signed [ssi_pkg::VALUE_W-1:0] value,
    output logic                               strobe,
    output logic signed [ssi_pkg::VALUE_W-1:0] value_res,
    output logic                               is_last,
    output logic                               none_found
);

    import ssi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_a_reg, cnt_a_next;
    logic [CW-1:0]        cnt_b_reg, cnt_b_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [VALUE_W-1:0]   pend_val_reg, pend_val_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 busy_reg, busy_next;
    logic                 strobe_reg, strobe_next;
    logic [VALUE_W-1:0]   res_val_reg, res_val_next;
    logic                 last_reg, last_next;
    logic                 none_reg, none_next;

    logic                 accept;
    logic                 we_a, we_b;
    logic [CW-1:0]        j_dec;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic [VALUE_W-1:0]   rdata_a, rdata_b;
    cmp_res_t             cmp_res;

    assign accept  = start && !busy_reg;
    assign j_dec   = j_reg - CW'(1);
    assign raddr_a = i_reg[AW-1:0];
    assign raddr_b = j_dec[AW-1:0];

    ssi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    ssi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    ssi_cmp u_cmp (
        .a   (rdata_a),
        .b   (rdata_b),
        .res (cmp_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pend_val_next = pend_val_reg;
        pend_vld_next = pend_vld_reg;
        busy_next     = busy_reg;
        strobe_next   = 1'b0;
        res_val_next  = res_val_reg;
        last_next     = last_reg;
        none_next     = none_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_LOAD_A:
                        begin
                            // append while room is left, drop otherwise
                            if (cnt_a_reg < CNT_FULL)
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                        end
                        REQ_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_FULL)
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end
                        end
                        REQ_RUN:
                        begin
                            // walk A from its start and B from its end
                            i_next        = '0;
                            j_next        = cnt_b_reg;
                            pend_vld_next = 1'b0;
                            busy_next     = 1'b1;
                            state_next    = ST_STEP;
                        end
                        default:
                        begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                // read addresses are driven now; data shows up in ST_CMP
                if ((i_reg < cnt_a_reg) && (j_reg != '0))
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (cmp_res.eq)
                begin
                    // release the held match now that another one follows
                    if (pend_vld_reg)
                    begin
                        strobe_next  = 1'b1;
                        res_val_next = pend_val_reg;
                        last_next    = 1'b0;
                        none_next    = 1'b0;
                    end
                    pend_val_next = rdata_a;
                    pend_vld_next = 1'b1;
                    i_next        = i_reg + CW'(1);
                    j_next        = j_dec;
                end
                else if (cmp_res.lt)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_dec;
                end
                state_next = ST_STEP;
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_vld_reg)
                begin
                    res_val_next = pend_val_reg;
                    none_next    = 1'b0;
                end
                else
                begin
                    res_val_next = '0;
                    none_next    = 1'b1;
                end
                pend_vld_next = 1'b0;
                cnt_a_next    = '0;
                cnt_b_next    = '0;
                busy_next     = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            pend_val_reg <= '0;
            pend_vld_reg <= 1'b0;
            busy_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            res_val_reg  <= '0;
            last_reg     <= 1'b0;
            none_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            pend_val_reg <= pend_val_next;
            pend_vld_reg <= pend_vld_next;
            busy_reg     <= busy_next;
            strobe_reg   <= strobe_next;
            res_val_reg  <= res_val_next;
            last_reg     <= last_next;
            none_reg     <= none_next;
        end
    end

    assign busy       = busy_reg;
    assign strobe     = strobe_reg;
    assign value_res  = res_val_reg;
    assign is_last    = last_reg;
    assign none_found = none_reg;

endmodule

@@ rtl/core/ssi_checker.sv @@
module ssi_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [1:0]                         req_type,
    input logic                               strobe,
    input logic signed [ssi_pkg::VALUE_W-1:0] value_res,
    input logic                               is_last,
    input logic                               none_found
);

    import ssi_pkg::*;

    // an empty result is always the only and final one, with a zero value
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && none_found) |-> (is_last && (value_res == '0)))
        else $error("none_found result without last mark or with nonzero value");

    // an accepted run raises busy
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_RUN)) |=> busy)
        else $error("run item taken but busy did not rise");

    // the run ends exactly when busy falls
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && is_last))
        else $error("busy fell without the last result");

    // intermediate results only while the run is still going
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !is_last) |-> busy)
        else $error("non-last result outside a run");

    // nothing follows the last result directly
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_last) |=> !strobe)
        else $error("result right after the last result");

endmodule

bind sorted_set_intersection ssi_checker u_ssi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .strobe     (strobe),
    .value_res  (value_res),
    .is_last    (is_last),
    .none_found (none_found)
);

@@ test/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ssi_pkg::*;

    localparam int SET_DEPTH   = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_ITEMS  = 140;
    // longest run: pointer steps over both full sets, plus margin
    localparam int TAIL_CYCLES = 4 * SET_DEPTH + 20;

    // request code 3 has no meaning; the block must drop it
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // one command waiting to be sent; wait_drain holds it back until the
    // block has returned every outstanding result
    typedef struct {
        logic [1:0]                 req;
        logic signed [VALUE_W-1:0]  val;
        bit                         wait_drain;
    } cmd_t;

    // one common element as the block should report it
    typedef struct {
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
        logic                       none;
    } hit_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [1:0]                 req_type = REQ_LOAD_A;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       busy;
    logic                       strobe;
    logic signed [VALUE_W-1:0]  value_res;
    logic                       is_last;
    logic                       none_found;

    cmd_t   pending_cmds[$];
    hit_t   expected_hits[$];

    // predictor copy of the two sets and their fill counts
    logic signed [VALUE_W-1:0]  set_a [0:SET_DEPTH-1];
    logic signed [VALUE_W-1:0]  set_b [0:SET_DEPTH-1];
    int                         fill_a;
    int                         fill_b;

    // generator-side fill counts, used only to tell which loads count as work
    int     gen_fill_a;
    int     gen_fill_b;
    int     useful_cmds;
    int     sent_cmds;
    int     error_count;
    int     cycle_count;

    logic signed [VALUE_W-1:0]  pool_a[$];
    logic signed [VALUE_W-1:0]  pool_b[$];

    sorted_set_intersection dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value      (value),
        .strobe     (strobe),
        .value_res  (value_res),
        .is_last    (is_last),
        .none_found (none_found)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Walk A upward and B downward, exactly as the block should, and queue the
    // common values it must report. Both counts are cleared afterwards.
    task automatic merge_sets();
        int   ia;
        int   jb;
        hit_t h;
        ia = 0;
        jb = fill_b;
        h.last = 1'b0;
        h.none = 1'b0;
        while (ia < fill_a && jb > 0)
        begin
            if (set_a[ia] < set_b[jb-1])
                ia++;
            else if (set_b[jb-1] < set_a[ia])
                jb--;
            else
            begin
                h.value = set_a[ia];
                expected_hits.push_back(h);
                ia++;
                jb--;
            end
        end
        h.last = 1'b1;
        if (expected_hits.size() == 0 || ia == -1)
        begin
            h.value = '0;
            h.none  = 1'b1;
            expected_hits.push_back(h);
        end
        fill_a = 0;
        fill_b = 0;
    endtask

    // Update the predicted sets for one accepted command.
    task automatic absorb_cmd(input logic [1:0] req, input logic signed [VALUE_W-1:0] v);
        int base_idx;
        base_idx = expected_hits.size();
        case (req)
            REQ_LOAD_A:
                if (fill_a < SET_DEPTH)
                begin
                    set_a[fill_a] = v;
                    fill_a++;
                end
            REQ_LOAD_B:
                if (fill_b < SET_DEPTH)
                begin
                    set_b[fill_b] = v;
                    fill_b++;
                end
            REQ_RUN:
                merge_run(base_idx);
            default: ;
        endcase
    endtask

    // A run adds at least one entry; only the newest one gets the last mark,
    // and the empty-intersection entry is added only when the walk found nothing.
    task automatic merge_run(input int base_idx);
        int   ia;
        int   jb;
        int   found;
        hit_t h;
        ia = 0;
        jb = fill_b;
        found = 0;
        h.last = 1'b0;
        h.none = 1'b0;
        while (ia < fill_a && jb > 0)
        begin
            if (set_a[ia] < set_b[jb-1])
                ia++;
            else if (set_b[jb-1] < set_a[ia])
                jb--;
            else
            begin
                h.value = set_a[ia];
                expected_hits.push_back(h);
                found++;
                ia++;
                jb--;
            end
        end
        if (found == 0)
        begin
            h.value = '0;
            h.last  = 1'b1;
            h.none  = 1'b1;
            expected_hits.push_back(h);
        end
        else
        begin
            h = expected_hits[base_idx + found - 1];
            h.last = 1'b1;
            expected_hits[base_idx + found - 1] = h;
        end
        fill_a = 0;
        fill_b = 0;
    endtask

    // Queue one command and keep track of which ones do real work.
    task automatic queue_cmd(input logic [1:0] req, input logic signed [VALUE_W-1:0] v,
                             input bit wait_drain);
        cmd_t c;
        c.req = req;
        c.val = v;
        c.wait_drain = wait_drain;
        pending_cmds.push_back(c);
        case (req)
            REQ_LOAD_A:
                if (gen_fill_a < SET_DEPTH)
                begin
                    gen_fill_a++;
                    useful_cmds++;
                end
            REQ_LOAD_B:
                if (gen_fill_b < SET_DEPTH)
                begin
                    gen_fill_b++;
                    useful_cmds++;
                end
            REQ_RUN:
            begin
                gen_fill_a = 0;
                gen_fill_b = 0;
                useful_cmds++;
            end
            default: ;
        endcase
    endtask

    // Narrow values collide often and give real intersections; wide ones
    // exercise every bit of the compare.
    function automatic logic signed [VALUE_W-1:0] pick_value(input bit wide);
        if (wide)
            return $urandom;
        return $signed($urandom_range(40)) - 20;
    endfunction

    task automatic order_values(ref logic signed [VALUE_W-1:0] q[$], input bit descending);
        logic signed [VALUE_W-1:0] t;
        int k;
        for (int i = 1; i < q.size(); i++)
        begin
            t = q[i];
            k = i - 1;
            while (k >= 0 && (descending ? (q[k] < t) : (q[k] > t)))
            begin
                q[k+1] = q[k];
                k--;
            end
            q[k+1] = t;
        end
    endtask

    // Build one well-formed pair of sets: A ascending, B descending, B partly
    // drawn from A so that matches occur. Loads of the two sets interleave.
    task automatic queue_set_pair(input bit overfill, input bit wait_drain);
        int  na;
        int  nb;
        int  ia;
        int  ib;
        bit  wide;
        na = overfill ? SET_DEPTH + $urandom_range(1, 4) : $urandom_range(SET_DEPTH);
        nb = overfill ? SET_DEPTH + $urandom_range(1, 4) : $urandom_range(SET_DEPTH);
        wide = 1'($urandom_range(1));
        pool_a.delete();
        pool_b.delete();
        repeat (na)
            pool_a.push_back(pick_value(wide));
        for (int k = 0; k < nb; k++)
        begin
            if (na > 0 && $urandom_range(1))
                pool_b.push_back(pool_a[$urandom_range(na - 1)]);
            else
                pool_b.push_back(pick_value(wide));
        end
        order_values(pool_a, 1'b0);
        order_values(pool_b, 1'b1);
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if (ib >= nb || (ia < na && $urandom_range(1)))
            begin
                queue_cmd(REQ_LOAD_A, pool_a[ia], wait_drain && ia == 0 && ib == 0);
                ia++;
            end
            else
            begin
                queue_cmd(REQ_LOAD_B, pool_b[ib], wait_drain && ia == 0 && ib == 0);
                ib++;
            end
        end
        queue_cmd(REQ_RUN, $urandom, wait_drain && na == 0 && nb == 0);
    endtask

    // Unsorted loads, stray codes and early runs.
    task automatic queue_noise();
        logic [1:0] r;
        repeat ($urandom_range(1, 12))
        begin
            r = 2'($urandom_range(3));
            queue_cmd(r, $urandom_range(1) ? $urandom : pick_value(1'b0), 1'b0);
        end
        queue_cmd(REQ_RUN, $urandom, 1'b0);
    endtask

    // Stimulus: directed corner cases, then random set pairs and noise.
    initial
    begin
        int seq_no;
        fill_a = 0;
        fill_b = 0;
        gen_fill_a = 0;
        gen_fill_b = 0;
        useful_cmds = 0;
        sent_cmds = 0;
        error_count = 0;

        // run on two empty sets
        queue_cmd(REQ_RUN, '0, 1'b0);
        // extremes on both sides; the common values include both ends of the range
        queue_cmd(REQ_LOAD_A, INT_MIN, 1'b0);
        queue_cmd(REQ_LOAD_A, -5, 1'b0);
        queue_cmd(REQ_LOAD_A, 0, 1'b0);
        queue_cmd(REQ_LOAD_A, 7, 1'b0);
        queue_cmd(REQ_LOAD_A, INT_MAX, 1'b0);
        queue_cmd(REQ_LOAD_B, INT_MAX, 1'b0);
        queue_cmd(REQ_LOAD_B, 7, 1'b0);
        queue_cmd(REQ_LOAD_B, 3, 1'b0);
        queue_cmd(REQ_LOAD_B, -5, 1'b0);
        queue_cmd(REQ_LOAD_B, INT_MIN, 1'b0);
        queue_cmd(REQ_RUN, INT_MAX, 1'b0);
        // stray code must leave the sets alone; hold the next load until the
        // previous run has drained
        queue_cmd(REQ_UNUSED, {VALUE_W{1'b1}}, 1'b0);
        queue_cmd(REQ_LOAD_A, 1, 1'b1);
        queue_cmd(REQ_RUN, '0, 1'b0);
        // the run above must have cleared A
        queue_cmd(REQ_LOAD_B, 9, 1'b0);
        queue_cmd(REQ_RUN, INT_MIN, 1'b0);

        useful_cmds = 0;
        seq_no = 0;
        while (useful_cmds < RAND_ITEMS)
        begin
            if ($urandom_range(99) < 20)
                queue_noise();
            else
                queue_set_pair(seq_no == 0 || $urandom_range(99) < 5,
                               $urandom_range(99) < 10);
            seq_no++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every command is taken and every result has come back
        while (pending_cmds.size() != 0 || start || expected_hits.size() != 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Driver: absorb the command taken at this edge, hold while the block is
    // busy, otherwise offer the next one unless idling or draining.
    always @(posedge clk)
    begin : drive
        bit go;
        bit quiet;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                absorb_cmd(req_type, value);
                sent_cmds++;
            end
            if (!(start && busy))
            begin
                // no random idling through a stretch in the middle of the run
                quiet = sent_cmds >= 120 && sent_cmds < 200;
                go = pending_cmds.size() != 0;
                if (go && !quiet && $urandom_range(99) < 9)
                    go = 1'b0;
                if (go && pending_cmds[0].wait_drain && (expected_hits.size() != 0 || busy))
                    go = 1'b0;
                if (go)
                begin
                    start    <= 1'b1;
                    req_type <= pending_cmds[0].req;
                    value    <= pending_cmds[0].val;
                    pending_cmds.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest predicted common element.
    always @(posedge clk)
    begin : watch
        hit_t h;
        if (rst_n && strobe)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result: value_res %0d is_last %0b none_found %0b",
                       value_res, is_last, none_found);
                error_count++;
            end
            else
            begin
                h = expected_hits.pop_front();
                if (value_res !== h.value)
                begin
                    $error("value_res: expected %0d, got %0d", h.value, value_res);
                    error_count++;
                end
                if (is_last !== h.last)
                begin
                    $error("is_last: expected %0b, got %0b", h.last, is_last);
                    error_count++;
                end
                if (none_found !== h.none)
                begin
                    $error("none_found: expected %0b, got %0b", h.none, none_found);
                    error_count++;
                end
            end
        end
    end

    // Hang guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule

@@ sim.f @@
rtl/core/ssi_pkg.sv
rtl/core/ssi_ram.sv
rtl/core/ssi_cmp.sv
rtl/core/sorted_set_intersection.sv
rtl/core/ssi_checker.sv
test/tb_top.sv
